// File: sv/assert_macros.svh
// Assertion macros used by the top level of the gait cycle statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define GCS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define GCS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define GCS_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define GCS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define GCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/gcs_pkg.sv
// Types and constants of the gait cycle statistics block.
`default_nettype none

package gcs_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_COUNT      = 4095;
   localparam int COUNT_BITS     = $clog2(MAX_COUNT + 1);
   localparam int SUM_BITS       = 32;
   localparam int LENGTH_BITS    = 12;
   localparam int AMP_BITS       = 15;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int DIV_STEP_BITS  = $clog2(SUM_BITS);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] angle;
      logic signed [SAMPLE_BITS-1:0] velocity;
   } req_type;

   typedef struct packed {
      logic                          cycle_end;
      logic signed [SAMPLE_BITS-1:0] mean_angle;
      logic signed [SAMPLE_BITS-1:0] mean_velocity;
      logic [LENGTH_BITS-1:0]        cycle_length;
      logic [AMP_BITS-1:0]           angle_amplitude;
      logic [AMP_BITS-1:0]           velocity_amplitude;
   } rsp_type;

   // One classified sample handed from the front end to the back end.
   typedef struct packed {
      logic                       boundary;
      logic signed [SUM_BITS-1:0] angle_sum;
      logic signed [SUM_BITS-1:0] velocity_sum;
      logic [COUNT_BITS-1:0]      count;
      logic [AMP_BITS-1:0]        angle_amp;
      logic [AMP_BITS-1:0]        velocity_amp;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_FINISH
   } back_state_type;

endpackage

`default_nettype wire

// File: sv/gcs_front.sv
// Front end: accepts samples, detects cycle boundaries and keeps the running sums.
`default_nettype none

module gcs_front
   import gcs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire q_status_type q_status,
   output logic         push,
   output job_type      push_job
);

   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic [COUNT_BITS-1:0]         last_period_ff, last_period_in;
   logic signed [SUM_BITS-1:0]    angle_sum_ff, angle_sum_in;
   logic signed [SUM_BITS-1:0]    velocity_sum_ff, velocity_sum_in;
   logic signed [SAMPLE_BITS-1:0] angle_max_ff, angle_max_in;
   logic signed [SAMPLE_BITS-1:0] angle_min_ff, angle_min_in;
   logic signed [SAMPLE_BITS-1:0] velocity_max_ff, velocity_max_in;
   logic signed [SAMPLE_BITS-1:0] velocity_min_ff, velocity_min_in;
   logic signed [SAMPLE_BITS-1:0] prev_velocity_ff, prev_velocity_in;

   logic                          boundary;
   logic [SAMPLE_BITS:0]          angle_span;
   logic [SAMPLE_BITS:0]          velocity_span;
   logic signed [SUM_BITS-1:0]    angle_ext;
   logic signed [SUM_BITS-1:0]    velocity_ext;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      boundary = req_data.velocity[SAMPLE_BITS-1] && !prev_velocity_ff[SAMPLE_BITS-1] &&
                 (prev_velocity_ff != '0) &&
                 ({count_ff, 1'b0} > {1'b0, last_period_ff});

      // Max is never below zero and min never above, so the span is non-negative.
      angle_span    = {angle_max_ff[SAMPLE_BITS-1], angle_max_ff} -
                      {angle_min_ff[SAMPLE_BITS-1], angle_min_ff};
      velocity_span = {velocity_max_ff[SAMPLE_BITS-1], velocity_max_ff} -
                      {velocity_min_ff[SAMPLE_BITS-1], velocity_min_ff};

      angle_ext    = {{(SUM_BITS-SAMPLE_BITS){req_data.angle[SAMPLE_BITS-1]}}, req_data.angle};
      velocity_ext = {{(SUM_BITS-SAMPLE_BITS){req_data.velocity[SAMPLE_BITS-1]}},
                      req_data.velocity};

      push_job.boundary     = boundary;
      push_job.angle_sum    = angle_sum_ff;
      push_job.velocity_sum = velocity_sum_ff;
      push_job.count        = count_ff;
      push_job.angle_amp    = angle_span[AMP_BITS:1];
      push_job.velocity_amp = velocity_span[AMP_BITS:1];
   end

   always_comb begin
      count_in         = count_ff;
      last_period_in   = last_period_ff;
      angle_sum_in     = angle_sum_ff;
      velocity_sum_in  = velocity_sum_ff;
      angle_max_in     = angle_max_ff;
      angle_min_in     = angle_min_ff;
      velocity_max_in  = velocity_max_ff;
      velocity_min_in  = velocity_min_ff;
      prev_velocity_in = prev_velocity_ff;
      if (push) begin
         prev_velocity_in = req_data.velocity;
         if (boundary) begin
            last_period_in  = count_ff;
            count_in        = '0;
            angle_sum_in    = '0;
            velocity_sum_in = '0;
            angle_max_in    = '0;
            angle_min_in    = '0;
            velocity_max_in = '0;
            velocity_min_in = '0;
         end else begin
            if (count_ff < COUNT_BITS'(MAX_COUNT)) begin
               count_in        = count_ff + 1'b1;
               angle_sum_in    = angle_sum_ff + angle_ext;
               velocity_sum_in = velocity_sum_ff + velocity_ext;
            end
            if (req_data.angle > angle_max_ff) angle_max_in = req_data.angle;
            if (req_data.angle < angle_min_ff) angle_min_in = req_data.angle;
            if (req_data.velocity > velocity_max_ff) velocity_max_in = req_data.velocity;
            if (req_data.velocity < velocity_min_ff) velocity_min_in = req_data.velocity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         last_period_ff   <= '0;
         angle_sum_ff     <= '0;
         velocity_sum_ff  <= '0;
         angle_max_ff     <= '0;
         angle_min_ff     <= '0;
         velocity_max_ff  <= '0;
         velocity_min_ff  <= '0;
         prev_velocity_ff <= '0;
      end else begin
         count_ff         <= count_in;
         last_period_ff   <= last_period_in;
         angle_sum_ff     <= angle_sum_in;
         velocity_sum_ff  <= velocity_sum_in;
         angle_max_ff     <= angle_max_in;
         angle_min_ff     <= angle_min_in;
         velocity_max_ff  <= velocity_max_in;
         velocity_min_ff  <= velocity_min_in;
         prev_velocity_ff <= prev_velocity_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/gcs_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none

module gcs_queue
   import gcs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   input  wire job_type push_job,
   input  wire          pop,
   output job_type      head_job,
   output q_status_type status
);

   job_type                   entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   fill_ff, fill_in;

   assign head_job     = entries_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: sv/gcs_div.sv
// Serial signed divider: sum divided by sample count, one quotient bit per cycle.
`default_nettype none

module gcs_div
   import gcs_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire signed [SUM_BITS-1:0]    dividend,
   input  wire [COUNT_BITS-1:0]         divisor,
   output logic                         done,
   output logic signed [SAMPLE_BITS-1:0] quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     neg_ff, neg_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [SUM_BITS-1:0]      quo_ff, quo_in;
   logic [COUNT_BITS-1:0]    rem_ff, rem_in;
   logic [COUNT_BITS-1:0]    divisor_ff, divisor_in;

   logic [COUNT_BITS:0]      rem_shift;
   logic [COUNT_BITS:0]      rem_sub;
   logic                     fits;
   logic [SUM_BITS-1:0]      signed_quo;

   assign done       = done_ff;
   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = signed_quo[SAMPLE_BITS-1:0];

   always_comb begin
      rem_shift  = {rem_ff, quo_ff[SUM_BITS-1]};
      rem_sub    = rem_shift - {1'b0, divisor_ff};
      fits       = (rem_shift >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      neg_in     = neg_ff;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         neg_in     = dividend[SUM_BITS-1];
         step_in    = '0;
         quo_in     = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_BITS-2:0], fits};
         rem_in  = fits ? rem_sub[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_BITS'(SUM_BITS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

endmodule

`default_nettype wire

// File: sv/gcs_back.sv
// Back end: computes the cycle means, keeps the latched statistics, drives the results.
`default_nettype none

module gcs_back
   import gcs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          q_empty,
   input  wire job_type head_job,
   output logic         pop,
   output logic         div_start,
   output logic         div_done,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output rsp_type      rsp_data
);

   back_state_type state_ff, state_in;
   rsp_type        lat_ff, lat_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           out_free;
   logic           load_plain;
   logic           load_cycle;
   logic           done_velocity;
   logic signed [SAMPLE_BITS-1:0] quo_angle;
   logic signed [SAMPLE_BITS-1:0] quo_velocity;
   rsp_type        cycle_stats;

   gcs_div u_div_angle (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head_job.angle_sum),
      .divisor  (head_job.count),
      .done     (div_done),
      .quotient (quo_angle)
   );

   gcs_div u_div_velocity (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head_job.velocity_sum),
      .divisor  (head_job.count),
      .done     (done_velocity),
      .quotient (quo_velocity)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_empty && head_job.boundary) state_in = BACK_DIVIDE;
         end
         BACK_DIVIDE: begin
            if (div_done && done_velocity) state_in = BACK_FINISH;
         end
         BACK_FINISH: begin
            if (out_free) state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      div_start  = 1'b0;
      load_plain = 1'b0;
      load_cycle = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            div_start  = !q_empty && head_job.boundary;
            load_plain = !q_empty && !head_job.boundary && out_free;
         end
         BACK_DIVIDE: begin
         end
         BACK_FINISH: begin
            load_cycle = out_free;
         end
         default: begin
         end
      endcase
      pop = load_plain || load_cycle;
   end

   always_comb begin
      cycle_stats.cycle_end          = 1'b1;
      cycle_stats.mean_angle         = (head_job.count == '0) ? '0 : quo_angle;
      cycle_stats.mean_velocity      = (head_job.count == '0) ? '0 : quo_velocity;
      cycle_stats.cycle_length       = LENGTH_BITS'(head_job.count);
      cycle_stats.angle_amplitude    = head_job.angle_amp;
      cycle_stats.velocity_amplitude = head_job.velocity_amp;

      lat_in       = lat_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_cycle) begin
         lat_in       = cycle_stats;
         rsp_data_in  = cycle_stats;
         rsp_valid_in = 1'b1;
      end else if (load_plain) begin
         rsp_data_in           = lat_ff;
         rsp_data_in.cycle_end = 1'b0;
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         lat_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lat_ff       <= lat_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// File: sv/gait_cycle_statistics.sv
// Top level of the gait cycle statistics block.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_data (angle, velocity)
//   rsp      out        rsp_valid/rsp_ready    rsp_data (cycle_end, means, length, amplitudes)
//
// A plain sample's result passes through the queue and then the result register when the back end is idle;
// a sample that closes a cycle also waits for the two 32-step serial dividers to compute its means.
// The front end accepts up to two samples ahead of the back end through the queue.
// Reset is synchronous and active high and clears all control and statistics state.
// A stall on rsp holds the result register; the front end stalls only on a full queue.
`default_nettype none
`include "assert_macros.svh"

module gait_cycle_statistics
   import gcs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output rsp_type      rsp_data
);

   // Classified samples travel from the front end to the back end as jobs.
   logic         push;
   logic         pop;
   job_type      push_job;
   job_type      head_job;
   q_status_type q_status;
   logic         div_start;
   logic         div_done;
   logic         length_ok;

   // The front end owns the boundary test and all running accumulators, so every
   // decision about a sample is made in the cycle it is transferred.
   gcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   gcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // The back end leaves a boundary job at the queue head until its means are
   // done, then releases it in the cycle the result register is loaded.
   gcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_status.empty),
      .head_job  (head_job),
      .pop       (pop),
      .div_start (div_start),
      .div_done  (div_done),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A closed cycle always holds at least one sample.
   assign length_ok = !(rsp_valid && rsp_data.cycle_end) || (rsp_data.cycle_length != '0);

   `GCS_ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !q_status.full, "queue overflow")
   `GCS_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, !q_status.empty, "queue underflow")
   `GCS_ASSERT_IMPLIES(a_start_ok, clock, reset, div_start, head_job.boundary && !pop, "bad start")
   `GCS_ASSERT_ALWAYS(a_cycle_length, clock, reset, length_ok, "cycle closed with zero length")
   `GCS_ASSERT_NEXT(a_div_hold, clock, reset, div_start, !pop && !div_done, "released early")

endmodule

`default_nettype wire
